FILE: src/u2g_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 to glyph index stream block.
// Holds field widths, the front-to-back request type and the decode helpers.
// It depends on nothing else.
package u2g_pkg;

  localparam int BYTE_W = 8;
  localparam int GW_W = 5;
  localparam int CP_W = 21;
  localparam int IDX_W = 8;
  localparam int SLOT_W = 16;
  localparam int TW_W = 20;
  localparam int PROD_W = SLOT_W + GW_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [GW_W-1:0] GW_RESET = 5'd8;
  localparam logic [GW_W-1:0] GW_MAX = 5'd16;
  localparam logic [CP_W-1:0] CP_QMARK = 21'h3F;
  localparam logic [SLOT_W-1:0] SLOT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_GLYPH,
    ACT_END
  } act_t;

  typedef struct packed {
    logic [1:0]      q_count;
    act_t            act;
    logic [CP_W-1:0] cp;
  } req_t;

  function automatic logic [IDX_W-1:0] font_index(input logic [CP_W-1:0] cp);
    logic [IDX_W-1:0] idx;
    idx = '0;
    if (cp >= 21'h20 && cp <= 21'h7E) begin
      idx = IDX_W'(cp - 21'h20);
    end else if (cp == 21'h401) begin
      idx = 8'd95;
    end else if (cp >= 21'h410 && cp <= 21'h44F) begin
      idx = IDX_W'(cp - 21'h410) + 8'd96;
    end else if (cp == 21'h451) begin
      idx = 8'd160;
    end
    return idx;
  endfunction

  function automatic logic [1:0] lead_need(input logic [BYTE_W-1:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      n = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

FILE: src/u2g_front.sv
`timescale 1ns / 1ps
// Front part: tracks the UTF-8 sequence state and turns each accepted byte
// into at most one request for the back part. Depends on u2g_pkg.
module u2g_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            text_byte,
  output logic                  req_valid,
  output u2g_pkg::req_t         req
);
  import u2g_pkg::*;

  logic [BYTE_W-1:0] lead;
  logic [BYTE_W-1:0] lead_next;
  logic [1:0]        pending;
  logic [1:0]        pending_next;
  logic [BYTE_W-1:0] held0;
  logic [BYTE_W-1:0] held1;
  logic              held_we;

  logic [1:0]        fresh_need;
  act_t              fresh_act;
  logic [CP_W-1:0]   fresh_cp;
  logic [1:0]        cur_need;
  logic [1:0]        held_cnt;
  logic              is_cont;
  logic [CP_W-1:0]   seq_cp;

  always_comb begin
    fresh_need = lead_need(text_byte);
    fresh_act = ACT_GLYPH;
    fresh_cp = CP_QMARK;
    if (text_byte == '0) begin
      fresh_act = ACT_END;
      fresh_cp = '0;
    end else if (!text_byte[7]) begin
      fresh_cp = CP_W'(text_byte);
    end else if (fresh_need != 2'd0) begin
      fresh_act = ACT_NONE;
    end
  end

  always_comb begin
    cur_need = lead_need(lead);
    held_cnt = cur_need - pending;
    is_cont = (text_byte[7:6] == 2'b10);
    case (cur_need)
      2'd1: seq_cp = {10'b0, lead[4:0], text_byte[5:0]};
      2'd2: seq_cp = {5'b0, lead[3:0], held0[5:0], text_byte[5:0]};
      2'd3: seq_cp = {lead[2:0], held0[5:0], held1[5:0], text_byte[5:0]};
      default: seq_cp = '0;
    endcase
  end

  always_comb begin
    lead_next = lead;
    pending_next = pending;
    held_we = 1'b0;
    req = '{q_count: 2'd0, act: ACT_NONE, cp: '0};
    if (pending == 2'd0) begin
      req.act = fresh_act;
      req.cp = fresh_cp;
      if (fresh_act == ACT_NONE) begin
        lead_next = text_byte;
        pending_next = fresh_need;
      end
    end else if (is_cont) begin
      if (pending == 2'd1) begin
        pending_next = 2'd0;
        req.act = (seq_cp == '0) ? ACT_END : ACT_GLYPH;
        req.cp = seq_cp;
      end else begin
        held_we = 1'b1;
        pending_next = pending - 2'd1;
      end
    end else begin
      req.q_count = held_cnt + 2'd1;
      req.act = fresh_act;
      req.cp = fresh_cp;
      pending_next = 2'd0;
      if (fresh_act == ACT_NONE) begin
        lead_next = text_byte;
        pending_next = fresh_need;
      end
    end
    req_valid = accept && ((req.act != ACT_NONE) || (req.q_count != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= '0;
      pending <= '0;
    end else if (accept) begin
      lead <= lead_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      if (held_cnt[0]) begin
        held1 <= text_byte;
      end else begin
        held0 <= text_byte;
      end
    end
  end

endmodule

FILE: src/u2g_fifo.sv
`timescale 1ns / 1ps
// Short request queue between the front and back parts.
// Depends on u2g_pkg for the request type and depth.
module u2g_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  u2g_pkg::req_t wr_data,
  input  logic          rd,
  output u2g_pkg::req_t rd_data,
  output logic          full,
  output logic          not_empty
);
  import u2g_pkg::*;

  req_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

FILE: src/u2g_back.sv
`timescale 1ns / 1ps
// Back part: expands each request into glyph and end results, keeps the glyph
// count and the glyph width register, and holds the result register.
// Depends on u2g_pkg.
module u2g_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [u2g_pkg::GW_W-1:0]      cfg_data,
  input  logic                          req_valid,
  input  u2g_pkg::req_t                 req,
  output logic                          req_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind,
  output logic [u2g_pkg::CP_W-1:0]      code_point,
  output logic [u2g_pkg::IDX_W-1:0]     glyph_index,
  output logic [u2g_pkg::SLOT_W-1:0]    glyph_slot,
  output logic [u2g_pkg::TW_W-1:0]      text_width,
  output logic                          last
);
  import u2g_pkg::*;

  logic [GW_W-1:0]   gwidth;
  logic [GW_W-1:0]   eff_w;
  logic [SLOT_W-1:0] count;
  logic [SLOT_W-1:0] count_next;
  logic [1:0]        qdone;
  logic              out_valid;
  logic              step;
  logic              emit_q;
  logic              r_end;
  logic [CP_W-1:0]   r_cp;
  logic              r_last;
  logic [SLOT_W-1:0] operand;
  logic [PROD_W-1:0] prod;

  assign eff_w = (gwidth > GW_MAX) ? GW_MAX : gwidth;
  assign empty = !out_valid;
  assign step = (!out_valid || pop) && req_valid;
  assign emit_q = (qdone != req.q_count);
  assign req_pop = step && r_last;

  always_comb begin
    if (emit_q) begin
      r_end = 1'b0;
      r_cp = CP_QMARK;
      r_last = ((qdone + 2'd1) == req.q_count) && (req.act == ACT_NONE);
    end else begin
      r_end = (req.act == ACT_END);
      r_cp = (req.act == ACT_GLYPH) ? req.cp : '0;
      r_last = 1'b1;
    end
    if (r_end) begin
      count_next = '0;
      operand = count;
    end else begin
      count_next = (count != SLOT_MAX) ? count + 1'b1 : count;
      operand = count_next;
    end
    prod = PROD_W'(operand) * PROD_W'(eff_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gwidth <= GW_RESET;
      count <= '0;
      qdone <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gwidth <= cfg_data;
      end
      if (step) begin
        count <= count_next;
        qdone <= r_last ? 2'd0 : qdone + 2'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind <= r_end;
      code_point <= r_cp;
      glyph_index <= r_end ? '0 : font_index(r_cp);
      glyph_slot <= count;
      text_width <= prod[TW_W-1:0];
      last <= r_last;
    end
  end

endmodule

FILE: src/utf8_to_glyph_index_stream_top.sv
// UTF-8 to glyph index stream, top level.
// A taken byte's request goes into the queue, and the back part moves it into the
// result register once that register is free. Throughput: one byte per cycle, and
// one result per cycle while pop keeps the result register free; a malformed sequence
// yields up to four results from one request, and the input stalls only while the
// queue is full. Reset (rst, synchronous, active high) clears the decode state, the
// glyph count and the queue, and sets the glyph width to 8; there is no clearing pass.
`timescale 1ns / 1ps
module utf8_to_glyph_index_stream_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [u2g_pkg::BYTE_W-1:0]    text_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [u2g_pkg::GW_W-1:0]      glyph_width,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind,
  output logic [u2g_pkg::CP_W-1:0]      code_point,
  output logic [u2g_pkg::IDX_W-1:0]     glyph_index,
  output logic [u2g_pkg::SLOT_W-1:0]    glyph_slot,
  output logic [u2g_pkg::TW_W-1:0]      text_width,
  output logic                          last
);
  import u2g_pkg::*;

  logic accept;
  logic wr;
  req_t wr_req;
  logic rd;
  req_t rd_req;
  logic rd_valid;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  u2g_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .req_valid (wr),
    .req       (wr_req)
  );

  u2g_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_data   (wr_req),
    .rd        (rd),
    .rd_data   (rd_req),
    .full      (full),
    .not_empty (rd_valid)
  );

  u2g_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (glyph_width),
    .req_valid   (rd_valid),
    .req         (rd_req),
    .req_pop     (rd),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .code_point  (code_point),
    .glyph_index (glyph_index),
    .glyph_slot  (glyph_slot),
    .text_width  (text_width),
    .last        (last)
  );

endmodule
